// ----- sv/ndhw_pkg.sv -----
`default_nettype none

package ndhw_pkg;

    // Bucket count and window size are powers of two: the bucket and slot
    // indexes are plain bit fields.
    localparam int BUCKETS    = 32;
    localparam int WINDOW     = 256;
    localparam int MAX_PROBES = 32;

    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WIN_W    = $clog2(WINDOW);
    localparam int PROBE_W  = $clog2(MAX_PROBES + 1);

    localparam logic [31:0] HASH_MUL = 32'hE20B7AC6;

    typedef struct packed {
        logic              mode;
        logic signed [7:0] ch;
    } t_in;

    typedef struct packed {
        logic        is_new;
        logic [63:0] name_hash;
    } t_res;

    typedef struct packed {
        logic [63:0]      hash;
        logic [WIN_W-1:0] next;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_LOOK,
        S_PROBE,
        S_INSERT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/name_dedup_hash_window.sv -----
`default_nettype none
// Channel   Ports                         Transfer
// input     start, busy, i_item (t_in)    start high while busy low
// result    o_res_valid, o_res (t_res)    o_res_valid high, one cycle
//
// A character item keeps busy high for two passes through the shared
// 32x32 multiplier, then the 64-bit add; no new item is taken meanwhile.
// An end-of-name item adds a bucket lookup and a chain slot read from the
// window RAM per probe (up to MAX_PROBES), plus an insert on a miss.
// Reset is synchronous and needs no clearing pass: bucket heads are flops.
// The result strobe cannot be stalled; it is shown while busy is low.

module name_dedup_hash_window
    import ndhw_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  t_in  i_item,
    output logic o_res_valid,
    output t_res o_res
);

    t_state r_state, n_state;

    logic [63:0]         r_hash, n_hash;
    t_in                 r_item;
    logic [63:0]         r_plo;
    logic [31:0]         r_phi;
    logic [63:0]         r_v;
    logic [BUCKET_W-1:0] r_bkt;
    logic [PROBE_W-1:0]  r_probes, n_probes;
    logic [WIN_W-1:0]    r_wr, n_wr;
    logic [WIN_W-1:0]    r_head [BUCKETS];

    // window RAM: stored hash and chain link per slot
    t_slot            r_win [WINDOW];
    t_slot            r_rd;
    logic             mem_re, mem_we;
    logic [WIN_W-1:0] mem_raddr, mem_waddr;
    t_slot            mem_wdata;

    logic             head_we;
    logic [WIN_W-1:0] ins_slot;
    logic [WIN_W-1:0] cur_head;

    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [63:0] sx;
    logic [63:0] sum;

    logic n_valid;
    t_res n_res;

    assign busy     = (r_state != S_IDLE);
    assign cur_head = r_head[r_bkt];
    assign ins_slot = (r_wr == '0) ? WIN_W'(1) : r_wr;

    assign mul_a = (r_state == S_MUL_LO) ? r_hash[31:0] : r_hash[63:32];
    assign mul_p = 64'(mul_a) * 64'(HASH_MUL);
    assign sx    = r_item.mode ? 64'd0 : 64'(signed'(r_item.ch));
    assign sum   = r_plo + {r_phi, 32'd0} + sx;

    always_comb begin
        n_state   = r_state;
        n_hash    = r_hash;
        n_probes  = r_probes;
        n_wr      = r_wr;
        n_valid   = 1'b0;
        n_res     = o_res;
        mem_re    = 1'b0;
        mem_raddr = cur_head;
        mem_we    = 1'b0;
        mem_waddr = ins_slot;
        mem_wdata = '{hash: r_v, next: cur_head};
        head_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_item.mode) begin
                    n_hash  = '0;
                    n_state = S_LOOK;
                end else begin
                    n_hash  = sum;
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                n_probes = PROBE_W'(MAX_PROBES);
                if (cur_head == '0) begin
                    n_state = S_INSERT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                mem_raddr = r_rd.next;
                if (r_rd.hash == r_v) begin
                    n_valid = 1'b1;
                    n_res   = '{is_new: 1'b0, name_hash: r_v};
                    n_state = S_IDLE;
                end else if (r_rd.next == '0 || r_probes == PROBE_W'(1)) begin
                    n_state = S_INSERT;
                end else begin
                    mem_re   = 1'b1;
                    n_probes = r_probes - PROBE_W'(1);
                end
            end
            S_INSERT: begin
                mem_we  = 1'b1;
                head_we = 1'b1;
                n_wr    = ins_slot + WIN_W'(1);
                n_valid = 1'b1;
                n_res   = '{is_new: 1'b1, name_hash: r_v};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_wr        <= '0;
            o_res_valid <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_head[b] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_wr        <= n_wr;
            o_res_valid <= n_valid;
            if (head_we) begin
                r_head[r_bkt] <= ins_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
        if (r_state == S_MUL_LO) begin
            r_plo <= mul_p;
        end
        if (r_state == S_MUL_HI) begin
            r_phi <= mul_p[31:0];
        end
        if (r_state == S_ADD) begin
            r_v   <= sum;
            r_bkt <= sum[32 +: BUCKET_W];
        end
        r_probes <= n_probes;
        o_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_win[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_win[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ndhw_checker.sv -----
`default_nettype none

module ndhw_checker
    import ndhw_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  start,
    input wire  busy,
    input t_in  i_item,
    input wire  o_res_valid
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after input transfer");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while busy");

    a_char_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_item.mode
        |=> !o_res_valid ##1 !o_res_valid ##1 !o_res_valid ##1 !o_res_valid)
        else $error("character transfer produced a result");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !busy && !o_res_valid)
        else $error("not idle after reset");

endmodule

bind name_dedup_hash_window ndhw_checker u_ndhw_checker (.*);

`default_nettype wire

// ----- sim/tb_name_dedup_hash_window.sv -----
`default_nettype none

module tb_name_dedup_hash_window;
    timeunit 1ns;
    timeprecision 1ps;

    import ndhw_pkg::*;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam int TARGET_BUCKET = 5;
    localparam int CHAIN_BURST   = 40;   // deeper than MAX_PROBES
    localparam int POOL_SIZE     = 3 * CHAIN_BURST;

    typedef logic signed [7:0] t_char;
    typedef t_char t_name[$];

    class name_table_model;
        logic [63:0]      running;
        logic [63:0]      slot_hash[WINDOW];
        logic [WIN_W-1:0] slot_link[WINDOW];
        logic [WIN_W-1:0] chain_head[BUCKETS];
        logic [WIN_W-1:0] next_slot;
        t_res             expected_verdicts[$];
        int               errors;
        int               checked;
        int               dups;
        int               walk_limits;

        function new();
            running = '0;
            next_slot = '0;
            foreach (slot_hash[i]) begin
                slot_hash[i] = '0;
                slot_link[i] = '0;
            end
            foreach (chain_head[i]) chain_head[i] = '0;
            errors = 0;
            checked = 0;
            dups = 0;
            walk_limits = 0;
        endfunction

        static function logic [63:0] fold_char(logic [63:0] h, t_char c);
            return h * {32'd0, HASH_MUL} + {{56{c[7]}}, c};
        endfunction

        static function logic [63:0] seal(logic [63:0] h);
            return h * {32'd0, HASH_MUL};
        endfunction

        static function int bucket_of(logic [63:0] v);
            return int'(v[63:32] % BUCKETS);
        endfunction

        function void note_transfer(t_in it);
            logic [63:0]      v;
            logic [WIN_W-1:0] j;
            logic [WIN_W-1:0] s;
            int               b;
            int               probes;
            bit               found;
            t_res             exp;

            if (it.mode == MODE_CHAR) begin
                running = fold_char(running, it.ch);
                return;
            end
            v = seal(running);
            b = bucket_of(v);
            j = chain_head[b];
            probes = MAX_PROBES;
            found = 1'b0;
            while (j != 0 && probes > 0 && !found) begin
                if (slot_hash[j] == v) begin
                    found = 1'b1;
                end else begin
                    j = slot_link[j];
                    probes--;
                end
            end
            if (!found && j != 0) walk_limits++;
            if (!found) begin
                s = next_slot;
                if (s == 0) s = WIN_W'(1);
                next_slot = s + WIN_W'(1);   // wraps at WINDOW
                slot_hash[s] = v;
                slot_link[s] = chain_head[b];
                chain_head[b] = s;
            end else begin
                dups++;
            end
            running = '0;
            exp.is_new = ~found;
            exp.name_hash = v;
            expected_verdicts.push_back(exp);
        endfunction

        function void check_verdict(t_res got);
            t_res exp;

            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result is_new=%0b name_hash=%h",
                         $time, got.is_new, got.name_hash);
                errors++;
                return;
            end
            exp = expected_verdicts.pop_front();
            checked++;
            if (got.is_new !== exp.is_new) begin
                $display("%0t: is_new mismatch, expected %0b actual %0b (hash %h)",
                         $time, exp.is_new, got.is_new, exp.name_hash);
                errors++;
            end
            if (got.name_hash !== exp.name_hash) begin
                $display("%0t: name_hash mismatch, expected %h actual %h",
                         $time, exp.name_hash, got.name_hash);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in  i_item = '0;
    logic busy;
    logic o_res_valid;
    t_res o_res;

    name_table_model names_seen = new();

    int    idle_pct;
    int    items_sent;
    int    names_sent;
    t_name history[$];
    t_name chain_pool[$];
    int    pool_next;

    name_dedup_hash_window DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // results first: an input taken on the same edge cannot have produced one yet
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid) names_seen.check_verdict(o_res);
            if (start && !busy) names_seen.note_transfer(i_item);
        end
    end

    task automatic send_item(input logic mode, input t_char c);
        int gap = 0;

        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item.mode <= mode;
        i_item.ch <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // ch is don't-care on the end-of-name transfer, so it gets random bits
    task automatic send_name(input t_name nm);
        foreach (nm[i]) send_item(MODE_CHAR, nm[i]);
        send_item(MODE_END, t_char'($urandom_range(255)));
        names_sent++;
        history.push_back(nm);
        if (history.size() > 300) void'(history.pop_front());
    endtask

    task automatic build_chain_pool();
        t_name       nm;
        logic [63:0] h;

        for (int a = 0; a < 256 && chain_pool.size() < POOL_SIZE; a++) begin
            for (int b = 0; b < 256 && chain_pool.size() < POOL_SIZE; b++) begin
                h = name_table_model::fold_char('0, t_char'(a));
                h = name_table_model::fold_char(h, t_char'(b));
                if (name_table_model::bucket_of(name_table_model::seal(h))
                        == TARGET_BUCKET) begin
                    nm = {t_char'(a), t_char'(b)};
                    chain_pool.push_back(nm);
                end
            end
        end
    endtask

    // fill one bucket past the probe limit, then look up its oldest and newest names
    task automatic chain_burst();
        int first;

        first = pool_next;
        for (int i = 0; i < CHAIN_BURST; i++) begin
            send_name(chain_pool[pool_next]);
            pool_next++;
        end
        send_name(chain_pool[first]);
        send_name(chain_pool[pool_next - 1]);
    endtask

    task automatic random_name();
        t_name nm;
        int    r;
        int    len;

        r = $urandom_range(99);
        if (r < 35 && history.size() > 0) begin
            nm = history[$urandom_range(history.size() - 1)];
        end else if (r < 45 && pool_next > 0) begin
            nm = chain_pool[$urandom_range(pool_next - 1)];
        end else if (r < 50) begin
            nm = {};
        end else begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0) begin
                    nm.push_back($urandom_range(1) ? 8'h80 : 8'h7f);
                end else begin
                    nm.push_back(t_char'($urandom_range(255)));
                end
            end
        end
        send_name(nm);
    endtask

    initial begin
        t_name nm;
        int    phase_pct[3];

        phase_pct = '{7, 55, 0};
        idle_pct = 0;
        items_sent = 0;
        names_sent = 0;
        pool_next = 0;
        build_chain_pool();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty name twice, single extreme characters, a four-character mix, one repeat
        idle_pct = phase_pct[0];
        nm = {};
        send_name(nm);
        send_name(nm);
        nm = {8'h80};
        send_name(nm);
        nm = {8'h7f};
        send_name(nm);
        nm = {8'h00};
        send_name(nm);
        nm = {8'hff};
        send_name(nm);
        nm = {8'h7f, 8'h80, 8'h00, 8'hff};
        send_name(nm);
        nm = {8'hff};
        send_name(nm);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = phase_pct[phase];
            chain_burst();
            while (items_sent < 300 * (phase + 1)) random_name();
        end

        start <= 1'b0;
        while (names_seen.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_PROBES + 8) @(posedge i_clk);

        $display("Sent %0d transfers forming %0d names; %0d results checked.",
                 items_sent, names_sent, names_seen.checked);
        $display("Duplicates: %0d, lookups cut off at the probe limit: %0d.",
                 names_seen.dups, names_seen.walk_limits);
        if (names_seen.errors == 0 && names_seen.expected_verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
